@@ src/gvc_pkg.sv @@
// Shared types and constants for the greedy vertex coloring block.
// No dependencies; compiled first.
package gvc_pkg;

  localparam int VertexW = 5;
  localparam int MaskW   = 32;
  localparam int ColorW  = 5;
  localparam int CountW  = 6;

  localparam int MaxVerticesDefault = 32;

  // Highest color the first-fit search can return, and the count ceiling.
  localparam logic [ColorW-1:0] MaxColor     = ColorW'(31);
  localparam logic [CountW-1:0] NumColorsMax = CountW'(32);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDrain,
    StFinish
  } gvc_state_e;

  typedef struct packed {
    logic capture;  // input beat taken this cycle
    logic scan;     // issue store read at current neighbor index
    logic commit;   // write back and load result register
  } gvc_cmd_t;

  typedef struct packed {
    logic scan_last;  // current index is the last slot
    logic out_free;   // result register can take a new beat
  } gvc_stat_t;

endpackage

@@ src/gvc_in_if.sv @@
// Input channel of the greedy vertex coloring block.
// Depends on gvc_pkg for field widths.
interface gvc_in_if import gvc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [VertexW-1:0] vertex;
  logic [MaskW-1:0]   neighbor_mask;
  logic               new_graph;

  modport source (output valid, vertex, neighbor_mask, new_graph, input ready);
  modport sink   (input valid, vertex, neighbor_mask, new_graph, output ready);
endinterface

@@ src/gvc_out_if.sv @@
// Result channel of the greedy vertex coloring block.
// Depends on gvc_pkg for field widths.
interface gvc_out_if import gvc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ColorW-1:0] assigned_color;
  logic [CountW-1:0] colors_used;

  modport source (output valid, assigned_color, colors_used, input ready);
  modport sink   (input valid, assigned_color, colors_used, output ready);
endinterface

@@ src/greedy_vertex_coloring_top.sv @@
// Top level of the greedy (first-fit) vertex coloring block.
// Depends on gvc_pkg, gvc_in_if, gvc_out_if, gvc_ctrl and gvc_dp.
//
// Usage:
//   in_i  : one beat per vertex, in coloring order: vertex index, its adjacency
//           row (bit k = adjacent to vertex k) and new_graph, which wipes all
//           colored marks and the color count before this vertex is handled.
//   out_o : one beat per input beat: assigned_color (smallest color not held by
//           an already colored neighbor) and colors_used (running count).
//   Timing: an idle/accept step, a neighbor scan of min(MAX_VERTICES,32)
//           slots (one store read per cycle), a drain step for the
//           registered read and a commit step. A new beat is accepted only
//           after the previous vertex has committed.
//   Stall: the result sits in an output register; the next vertex is accepted
//           and scanned meanwhile, and waits in its commit step only if the
//           previous result has still not been taken.
//   Reset: rst_ni (async, active low) clears colored flags, the count, the
//           controller and the output valid; the color store is not cleared.
//   Self bits, bits of uncolored vertices and bits at or above MAX_VERTICES
//   are ignored; a repeated vertex is recolored.
module greedy_vertex_coloring_top import gvc_pkg::*; #(
  parameter int MAX_VERTICES = MaxVerticesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gvc_in_if.sink     in_i,
  gvc_out_if.source  out_o
);

  gvc_cmd_t  cmd;
  gvc_stat_t stat;

  gvc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gvc_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .vertex_i         (in_i.vertex),
    .neighbor_mask_i  (in_i.neighbor_mask),
    .new_graph_i      (in_i.new_graph),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .assigned_color_o (out_o.assigned_color),
    .colors_used_o    (out_o.colors_used)
  );

endmodule

@@ src/gvc_ctrl.sv @@
// Controller FSM: accept, neighbor scan, drain, commit.
// Depends on gvc_pkg; drives gvc_dp through gvc_cmd_t.
module gvc_ctrl import gvc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  gvc_stat_t stat_i,
  output gvc_cmd_t  cmd_o
);

  gvc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (in_valid_i) state_d = StScan;
      StScan:   if (stat_i.scan_last) state_d = StDrain;
      StDrain:  state_d = StFinish;
      StFinish: if (stat_i.out_free) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      StScan:   cmd_o.scan   = 1'b1;
      StDrain:  ;
      StFinish: cmd_o.commit = stat_i.out_free;
      default:  ;
    endcase
  end

endmodule

@@ src/gvc_dp.sv @@
// Datapath: color store, colored flags, used-color set, count, result register.
// Depends on gvc_pkg; sequenced by gvc_ctrl.
module gvc_dp import gvc_pkg::*; #(
  parameter int MAX_VERTICES = MaxVerticesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gvc_cmd_t           cmd_i,
  output gvc_stat_t          stat_o,
  input  logic [VertexW-1:0] vertex_i,
  input  logic [MaskW-1:0]   neighbor_mask_i,
  input  logic               new_graph_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ColorW-1:0]  assigned_color_o,
  output logic [CountW-1:0]  colors_used_o
);

  // Only the first MaskW vertices can ever be neighbors or be stored.
  localparam int NumSlots = (MAX_VERTICES < MaskW) ? MAX_VERTICES : MaskW;
  localparam int IdxW     = $clog2(NumSlots);
  localparam int UsedW    = 31;  // colors 0..30 decide; 31 is the fallback

  logic [VertexW-1:0]  vertex_q;
  logic [NumSlots-1:0] mask_q;
  logic [IdxW-1:0]     k_q;
  logic                qual_q;
  logic                acc_en_q;
  logic [ColorW-1:0]   rd_data_q;
  logic [UsedW-1:0]    used_q;
  logic [NumSlots-1:0] flags_q;
  logic [CountW-1:0]   count_q, count_d;
  logic                out_valid_q;
  logic [ColorW-1:0]   out_color_q;
  logic [CountW-1:0]   out_count_q;
  logic [ColorW-1:0]   pick;
  logic                slot_ok;
  logic [IdxW-1:0]     wr_idx;

  logic [ColorW-1:0] store_mem [NumSlots];

  assign slot_ok = int'(vertex_q) < NumSlots;
  assign wr_idx  = vertex_q[IdxW-1:0];

  assign stat_o.scan_last = (k_q == IdxW'(NumSlots - 1));
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  // Payload captures, scan index, read qualifier, store read and write, result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      vertex_q <= vertex_i;
      mask_q   <= neighbor_mask_i[NumSlots-1:0];
      k_q      <= '0;
    end else if (cmd_i.scan) begin
      k_q <= k_q + IdxW'(1);
    end
    qual_q    <= mask_q[k_q] && flags_q[k_q] && (VertexW'(k_q) != vertex_q);
    rd_data_q <= store_mem[k_q];
    if (cmd_i.commit && slot_ok) begin
      store_mem[wr_idx] <= pick;
    end
    if (cmd_i.commit) begin
      out_color_q <= pick;
      out_count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      used_q <= '0;
    end else if (acc_en_q && qual_q) begin
      used_q <= used_q | (UsedW'(1) << rd_data_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_en_q    <= 1'b0;
      flags_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_en_q <= cmd_i.scan;
      if (cmd_i.capture && new_graph_i) begin
        flags_q <= '0;
        count_q <= '0;
      end else if (cmd_i.commit) begin
        count_q <= count_d;
        if (slot_ok) flags_q[wr_idx] <= 1'b1;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // First free color, lowest index wins.
  always_comb begin
    pick = MaxColor;
    for (int j = UsedW - 1; j >= 0; j--) begin
      if (!used_q[j]) pick = ColorW'(j);
    end
  end

  assign count_d = ((CountW'(pick) == count_q) && (count_q < NumColorsMax))
                   ? count_q + CountW'(1) : count_q;

  assign out_valid_o      = out_valid_q;
  assign assigned_color_o = out_color_q;
  assign colors_used_o    = out_count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= NumColorsMax)
    else $error("color count above ceiling");

  a_first_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> CountW'(pick) <= count_q)
    else $error("picked color skips past count");

  a_new_graph_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.capture && new_graph_i) |=> (flags_q == '0 && count_q == '0))
    else $error("new graph did not clear state");

  a_commit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("commit did not present a result");

endmodule
